FILE: src/aged_purge_queue_core_defines.svh
// Assertion macros for the aged purge queue core.
// Each expects clk and rst in the scope where it is used.
`ifndef AGED_PURGE_QUEUE_CORE_DEFINES_SVH
`define AGED_PURGE_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define APQ_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("aged purge queue: implication check failed");
// Next-cycle implication.
`define APQ_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("aged purge queue: next-cycle check failed");
`else
`define APQ_ASSERT_IMP(label, cond, prop)
`define APQ_ASSERT_NXT(label, cond, prop)
`endif

`endif

FILE: src/apq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

  // Default geometry
  localparam int QUEUE_DEPTH_DEF = 256;
  localparam int PAGE_SHIFT_DEF  = 12;

  // Operation codes
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Stop reasons
  localparam logic [1:0] STOP_NONE    = 2'd0;
  localparam logic [1:0] STOP_YOUNG   = 2'd1;
  localparam logic [1:0] STOP_BUDGET  = 2'd2;
  localparam logic [1:0] STOP_ENQUEUE = 2'd3;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_QUOTA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CALL_QUOTA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMMEDIATE  = 2'd3;

  localparam logic [15:0] MIN_AGE_RST    = 16'd4;
  localparam logic [19:0] PAGE_QUOTA_RST = 20'd256;
  localparam logic [5:0]  CALL_QUOTA_RST = 6'd8;

  typedef struct packed {
    logic        operation;
    logic [47:0] segment_base;
    logic [15:0] page_index;
    logic [15:0] page_count;
    logic [31:0] epoch_now;
  } in_item_t;

  typedef struct packed {
    logic        purge_valid;
    logic [47:0] purge_address;
    logic [27:0] purge_length;
    logic        dropped_oldest;
    logic [1:0]  stop_reason;
    logic [7:0]  queue_length;
    logic        last;
  } out_item_t;

  // One stored run
  typedef struct packed {
    logic [47:0] base;
    logic [15:0] page_index;
    logic [15:0] page_count;
    logic [31:0] epoch;
  } entry_t;

endpackage

`default_nettype wire

FILE: src/apq_ring_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module apq_ring_mem #(
  parameter int DEPTH = apq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire apq_pkg::entry_t          wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output apq_pkg::entry_t               rd_data
);

  apq_pkg::entry_t mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: src/aged_purge_queue_core.sv
// Aged purge queue core: a ring of retired page runs released after a delay.
// in_data/in_valid/in_ready carries one beat per operation: an enqueue stores
// a run with its epoch (dropping the oldest run when the ring is full), or in
// immediate mode with a zero minimum age purges it at once; a tick drains
// aged runs from the head within the page and call budgets.
// out_data/out_valid/out_ready returns the result beats; the final beat of an
// operation has last set and carries the stop reason.
// cfg_we/cfg_index/cfg_data writes one of the four control registers per
// cycle; write them only while no operation is in flight.
// An enqueue result is registered at the accepting edge and offered from the
// next cycle, so enqueues run at one per cycle unless the output stalls. A tick
// is accepted, drains one run per step, then ends with a closing step; each
// step judges the registered head entry; no new beat is accepted in a tick.
// Reset empties the ring and loads the register defaults; the entry memory is
// not cleared, as only entries between head and tail are ever read.
// A stalled receiver holds the output register and freezes the drain in place
// until the beat is taken; the next beat loads as the current one leaves.
`timescale 1ns / 1ps
`default_nettype none
`include "aged_purge_queue_core_defines.svh"

module aged_purge_queue_core #(
  parameter int QUEUE_DEPTH = apq_pkg::QUEUE_DEPTH_DEF,
  parameter int PAGE_SHIFT  = apq_pkg::PAGE_SHIFT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire apq_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output apq_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [apq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [apq_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // Ring helpers
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [7:0] ring_len(input logic [IDX_W-1:0] h,
                                          input logic [IDX_W-1:0] t);
    logic [IDX_W:0] diff;
    diff = {1'b0, t} - {1'b0, h};
    if (t < h) begin
      diff = diff + (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return 8'(diff[IDX_W-1:0]);
  endfunction

  function automatic logic [47:0] purge_addr(input logic [47:0] base,
                                             input logic [15:0] idx);
    logic [47:0] off;
    off = 48'(idx) << PAGE_SHIFT;
    return base + off;
  endfunction

  function automatic logic [27:0] purge_len(input logic [15:0] cnt);
    logic [47:0] wide;
    wide = 48'(cnt) << PAGE_SHIFT;
    return wide[27:0];
  endfunction

  // Control registers
  logic [15:0] min_age;
  logic [19:0] page_quota;
  logic [5:0]  call_quota;
  logic        immediate_on_zero;

  // Ring and drain state
  logic             state;
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [31:0]      tick_epoch;
  logic [19:0]      pages_left;
  logic [5:0]       calls_left;
  logic             pend_valid;
  logic [47:0]      pend_addr;
  logic [27:0]      pend_len;

  // Memory ports
  logic             wr_en;
  logic [IDX_W-1:0] rd_addr;
  apq_pkg::entry_t  wr_data;
  apq_pkg::entry_t  rd_data;

  // Decode
  logic             out_free;
  logic             in_fire;
  logic             is_enq;
  logic             imm;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_inc;
  logic             full;
  logic             empty;
  logic [31:0]      age;
  logic             young;
  logic             spent;
  logic             drain_step;
  logic             take;
  logic             finish;
  logic [19:0]      pages_after;
  logic             out_load;
  apq_pkg::out_item_t out_next;

  apq_ring_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_ring_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign is_enq   = in_data.operation == apq_pkg::OP_ENQUEUE;
  assign imm      = immediate_on_zero && (min_age == '0);
  assign head_inc = ring_next(head);
  assign tail_inc = ring_next(tail);
  assign full     = tail_inc == head;
  assign empty    = head == tail;

  // Judge the head entry returned by the memory
  assign age        = tick_epoch - rd_data.epoch;
  assign young      = age < {16'b0, min_age};
  assign spent      = (pages_left == '0) || (calls_left == '0);
  assign drain_step = (state == ST_DRAIN) && out_free;
  assign take       = drain_step && !empty && !young && !spent;
  assign finish     = drain_step && !take;

  assign pages_after = (pages_left > 20'(rd_data.page_count)) ?
                       pages_left - 20'(rd_data.page_count) : '0;

  // Prefetch the next head while draining; otherwise keep reading the head.
  // Writes happen only in idle enqueues, so a drain read never meets a write.
  assign rd_addr = take ? head_inc : head;

  assign wr_en              = in_fire && is_enq && !imm;
  assign wr_data.base       = in_data.segment_base;
  assign wr_data.page_index = in_data.page_index;
  assign wr_data.page_count = in_data.page_count;
  assign wr_data.epoch      = in_data.epoch_now;

  // Build the next result beat
  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (in_fire && is_enq) begin
      out_load             = 1'b1;
      out_next.stop_reason = apq_pkg::STOP_ENQUEUE;
      out_next.last        = 1'b1;
      if (imm) begin
        out_next.purge_valid   = 1'b1;
        out_next.purge_address = purge_addr(in_data.segment_base, in_data.page_index);
        out_next.purge_length  = purge_len(in_data.page_count);
        out_next.queue_length  = ring_len(head, tail);
      end else begin
        out_next.dropped_oldest = full;
        out_next.queue_length   = ring_len(full ? head_inc : head, tail_inc);
      end
    end else if (take && pend_valid) begin
      out_load               = 1'b1;
      out_next.purge_valid   = 1'b1;
      out_next.purge_address = pend_addr;
      out_next.purge_length  = pend_len;
      out_next.stop_reason   = apq_pkg::STOP_NONE;
      out_next.queue_length  = ring_len(head, tail);
    end else if (finish) begin
      out_load              = 1'b1;
      out_next.purge_valid  = pend_valid;
      if (pend_valid) begin
        out_next.purge_address = pend_addr;
        out_next.purge_length  = pend_len;
      end
      if (empty) begin
        out_next.stop_reason = apq_pkg::STOP_NONE;
      end else if (young) begin
        out_next.stop_reason = apq_pkg::STOP_YOUNG;
      end else begin
        out_next.stop_reason = apq_pkg::STOP_BUDGET;
      end
      out_next.queue_length = ring_len(head, tail);
      out_next.last         = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_age           <= apq_pkg::MIN_AGE_RST;
      page_quota        <= apq_pkg::PAGE_QUOTA_RST;
      call_quota        <= apq_pkg::CALL_QUOTA_RST;
      immediate_on_zero <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        apq_pkg::CFG_MIN_AGE:    min_age           <= cfg_data[15:0];
        apq_pkg::CFG_PAGE_QUOTA: page_quota        <= cfg_data[19:0];
        apq_pkg::CFG_CALL_QUOTA: call_quota        <= cfg_data[5:0];
        apq_pkg::CFG_IMMEDIATE:  immediate_on_zero <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: idle for enqueues and tick start, drain one run per step
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      tail       <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (is_enq) begin
              if (!imm) begin
                tail <= tail_inc;
                if (full) begin
                  head <= head_inc;
                end
              end
            end else begin
              state      <= ST_DRAIN;
              pend_valid <= 1'b0;
            end
          end
        end
        ST_DRAIN: begin
          if (take) begin
            head       <= head_inc;
            pend_valid <= 1'b1;
          end else if (finish) begin
            state      <= ST_IDLE;
            pend_valid <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Tick working values
  always_ff @(posedge clk) begin
    if (in_fire && !is_enq) begin
      tick_epoch <= in_data.epoch_now;
      pages_left <= page_quota;
      calls_left <= call_quota;
    end else if (take) begin
      pages_left <= pages_after;
      calls_left <= calls_left - 1'b1;
    end
    if (take) begin
      pend_addr <= purge_addr(rd_data.base, rd_data.page_index);
      pend_len  <= purge_len(rd_data.page_count);
    end
  end

  // Output register: drop the beat when taken, load the next in its place
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Checks
  `APQ_ASSERT_NXT(a_enq_leaves_entry, in_fire && is_enq && !imm, head != tail)
  `APQ_ASSERT_IMP(a_calls_bounded, state == ST_DRAIN, calls_left <= call_quota)
  `APQ_ASSERT_IMP(a_drop_on_enqueue, out_valid && out_data.dropped_oldest, out_data.stop_reason == apq_pkg::STOP_ENQUEUE && !out_data.purge_valid && out_data.last)
  `APQ_ASSERT_IMP(a_idle_tick_single, out_valid && !out_data.purge_valid && out_data.stop_reason != apq_pkg::STOP_ENQUEUE, out_data.last && out_data.purge_address == '0)

endmodule

`default_nettype wire
